// ===== rtl/bpp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_pkg
// Types and constants shared by the bank paging and I/O port controller.
// ----------------------------------------------------------------------------

package bpp_pkg;

  localparam int unsigned KEY_ROWS = 8;
  localparam int unsigned ROW_IDX_W = $clog2(KEY_ROWS);

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_KEY_SET = 2'd2,
    CMD_NONE    = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    SRC_ROM_BANK = 2'd0,
    SRC_DISK_ROM = 2'd1,
    SRC_RAM0     = 2'd2,
    SRC_UNUSED   = 2'd3
  } rom_source_t;

  localparam logic [2:0] MODEL_48_A  = 3'd0;
  localparam logic [2:0] MODEL_48_B  = 3'd1;
  localparam logic [2:0] MODEL_EXT   = 3'd4;
  localparam logic [2:0] MODEL_RESET = 3'd1;

  localparam logic [7:0] EXT_PORT_HIGH = 8'h1F;
  localparam logic [7:0] PORT_FE       = 8'hFE;
  localparam logic [7:0] PORT_JOY      = 8'h1F;
  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [2:0] BORDER_RESET  = 3'b111;
  localparam logic [2:0] SCREEN_NORMAL = 3'd5;
  localparam logic [2:0] SCREEN_SHADOW = 3'd7;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] port_low;
    logic [7:0] port_high;
    logic [7:0] write_data;
    logic [2:0] key_row;
    logic       disk_rom_active;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] rom_source;
    logic [1:0] rom_bank;
    logic [3:0] ram_page;
    logic [2:0] screen_page;
    logic [2:0] border_color;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/bank_paging_port_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bank_paging_port_controller_top
// I/O port decoder and memory bank selector with one result per bus access.
// ----------------------------------------------------------------------------
// Each input item is a port write, a port read or a keyboard row update, and
// each one produces exactly one result item: the read byte (255 for anything
// but a read) and the memory map after the access, given as bank numbers.
// Both channels use valid/ready. An accepted item is held in an input
// register; the decode and register update happen on the way from there to
// the output register, which then offers the result.
// One item is taken every cycle while the output side keeps up; the output
// register alone sets that rate. When the receiver stalls, the result stays
// in the output register, one more item waits in the input register, and
// in_ready drops until the result is taken.
// The user must write the machine model through cfg_we/cfg_data only while
// the block is idle; the block does not enforce this. Reset empties both
// registers, sets the model to the 48K variant, clears the paging registers,
// selects screen page 5, sets the border to 7 and releases every keyboard key.
// ----------------------------------------------------------------------------

module bank_paging_port_controller_top (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic in_valid,
  output                     logic in_ready,
  input  wire bpp_pkg::in_item_t  in_item,
  output                     logic out_valid,
  input  wire                logic out_ready,
  output      bpp_pkg::out_item_t out_item,
  input  wire                logic cfg_we,
  input  wire          logic [2:0] cfg_data
);

  logic              s1_valid;
  bpp_pkg::in_item_t s1_item;
  logic              s1_advance;

  logic [2:0] machine_model;
  logic [7:0] paging_reg;
  logic [7:0] extended_paging_reg;
  logic [1:0] rom_select;
  logic       ram0_as_rom;
  logic [3:0] ram_select;
  logic [2:0] screen_select;
  logic [2:0] border;
  logic [7:0] joystick_reg;
  logic [7:0] keyboard_rows [bpp_pkg::KEY_ROWS];

  logic [7:0] paging_reg_next;
  logic [7:0] extended_paging_reg_next;
  logic [1:0] rom_select_next;
  logic       ram0_as_rom_next;
  logic [3:0] ram_select_next;
  logic [2:0] screen_select_next;
  logic [2:0] border_next;
  logic [7:0] joystick_reg_next;
  logic [7:0] key_and;
  logic       do_write;
  logic       is_48k;

  bpp_pkg::out_item_t result;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  assign is_48k   = (machine_model == bpp_pkg::MODEL_48_A) ||
                    (machine_model == bpp_pkg::MODEL_48_B);
  assign do_write = (s1_item.command == bpp_pkg::CMD_WRITE) && !s1_item.disk_rom_active;

  always_comb begin
    paging_reg_next          = paging_reg;
    extended_paging_reg_next = extended_paging_reg;
    rom_select_next          = rom_select;
    ram0_as_rom_next         = ram0_as_rom;
    ram_select_next          = ram_select;
    screen_select_next       = screen_select;
    border_next              = border;
    joystick_reg_next        = joystick_reg;
    if (do_write) begin
      if (!s1_item.port_low[1]) begin
        if (s1_item.port_high == bpp_pkg::EXT_PORT_HIGH) begin
          if (machine_model == bpp_pkg::MODEL_EXT) begin
            extended_paging_reg_next = s1_item.write_data;
            ram0_as_rom_next         = s1_item.write_data[0];
            rom_select_next          = s1_item.write_data[1] ? 2'd2 : {1'b0, paging_reg[4]};
            ram_select_next          = {s1_item.write_data[4], paging_reg[2:0]};
          end
        end else if (!s1_item.port_high[7]) begin
          if (!is_48k && !paging_reg[5]) begin
            paging_reg_next    = s1_item.write_data;
            screen_select_next = s1_item.write_data[3] ? bpp_pkg::SCREEN_SHADOW
                                                       : bpp_pkg::SCREEN_NORMAL;
            if (machine_model == bpp_pkg::MODEL_EXT) begin
              if (!extended_paging_reg[1]) begin
                rom_select_next = {1'b0, s1_item.write_data[4]};
              end
              ram_select_next = {extended_paging_reg[4], s1_item.write_data[2:0]};
            end else begin
              rom_select_next = {1'b0, s1_item.write_data[4]};
              ram_select_next = {1'b0, s1_item.write_data[2:0]};
            end
          end
        end
      end else if (s1_item.port_low == bpp_pkg::PORT_FE) begin
        border_next = s1_item.write_data[2:0];
      end else if (s1_item.port_low == bpp_pkg::PORT_JOY) begin
        joystick_reg_next = s1_item.write_data;
      end
    end
  end

  always_comb begin
    key_and = bpp_pkg::BYTE_IDLE;
    for (int i = 0; i < bpp_pkg::KEY_ROWS; i++) begin
      if (!s1_item.port_high[i]) begin
        key_and = key_and & keyboard_rows[i];
      end
    end
  end

  always_comb begin
    result = '0;
    result.read_data = bpp_pkg::BYTE_IDLE;
    if (s1_item.command == bpp_pkg::CMD_READ) begin
      if (s1_item.port_low == bpp_pkg::PORT_JOY) begin
        result.read_data = joystick_reg;
      end else if (s1_item.port_low == bpp_pkg::PORT_FE) begin
        result.read_data = key_and;
      end
    end
    if (s1_item.disk_rom_active) begin
      result.rom_source = bpp_pkg::SRC_DISK_ROM;
    end else if (ram0_as_rom_next) begin
      result.rom_source = bpp_pkg::SRC_RAM0;
    end else begin
      result.rom_source = bpp_pkg::SRC_ROM_BANK;
    end
    result.rom_bank     = (result.rom_source == bpp_pkg::SRC_ROM_BANK) ? rom_select_next
                                                                       : 2'd0;
    result.ram_page     = ram_select_next;
    result.screen_page  = screen_select_next;
    result.border_color = border_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_model       <= bpp_pkg::MODEL_RESET;
      paging_reg          <= '0;
      extended_paging_reg <= '0;
      rom_select          <= '0;
      ram0_as_rom         <= 1'b0;
      ram_select          <= '0;
      screen_select       <= bpp_pkg::SCREEN_NORMAL;
      border              <= bpp_pkg::BORDER_RESET;
      joystick_reg        <= '0;
      for (int i = 0; i < bpp_pkg::KEY_ROWS; i++) begin
        keyboard_rows[i] <= bpp_pkg::BYTE_IDLE;
      end
    end else begin
      if (cfg_we) begin
        machine_model <= cfg_data;
      end
      if (s1_advance) begin
        paging_reg          <= paging_reg_next;
        extended_paging_reg <= extended_paging_reg_next;
        rom_select          <= rom_select_next;
        ram0_as_rom         <= ram0_as_rom_next;
        ram_select          <= ram_select_next;
        screen_select       <= screen_select_next;
        border              <= border_next;
        joystick_reg        <= joystick_reg_next;
        if (s1_item.command == bpp_pkg::CMD_KEY_SET) begin
          keyboard_rows[s1_item.key_row[bpp_pkg::ROW_IDX_W-1:0]] <= s1_item.write_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance) begin
      out_item <= result;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("Input side stalled without a waiting result.");

  a_screen_page: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.screen_page == bpp_pkg::SCREEN_NORMAL ||
                   out_item.screen_page == bpp_pkg::SCREEN_SHADOW))
    else $error("Screen page is neither 5 nor 7.");

  a_rom_bank_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.rom_source != bpp_pkg::SRC_ROM_BANK) |-> (out_item.rom_bank == 2'd0))
    else $error("ROM bank reported while another ROM source is selected.");

  a_rom_source_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.rom_source != bpp_pkg::SRC_UNUSED))
    else $error("Unused ROM source code reported.");

  a_lock_holds: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(paging_reg[5])) |-> (paging_reg == $past(paging_reg)))
    else $error("Paging register changed while locked.");

endmodule

`default_nettype wire
